FILE: rtl/sigmoid_activation_gradient_unit_defines.svh
// assertion macros for the sigmoid activation and gradient unit
// used by the top level only; needs a clock named clk and a reset named rst in scope
`ifndef SIGMOID_ACTIVATION_GRADIENT_UNIT_DEFINES_SVH
`define SIGMOID_ACTIVATION_GRADIENT_UNIT_DEFINES_SVH
`ifndef SYNTH
`define SGAG_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sgag: same-cycle check failed");
`define SGAG_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sgag: next-cycle check failed");
`else
`define SGAG_ASSERT_SAME(label, ante, cons)
`define SGAG_ASSERT_NEXT(label, ante, cons)
`endif
`endif

FILE: rtl/sgag_pkg.sv
// shared types, constants and the plan sigmoid function
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package sgag_pkg;

  localparam int StoreDepthDefault = 1024;
  localparam int FeatureCountW     = 11;
  localparam int IndexW            = 10;
  localparam int DataW             = 16;
  localparam int ProdW             = IndexW + FeatureCountW;
  localparam int FullAddrW         = ProdW + 1;
  localparam int PAddrW            = 3;
  localparam int PDataW            = 32;

  // register index taken from paddr[2]
  localparam logic RegIdxFeatureCount = 1'b0;
  localparam logic [FeatureCountW-1:0] FeatureCountReset = FeatureCountW'(1);

  typedef enum logic {
    CmdForward  = 1'b0,
    CmdBackward = 1'b1
  } cmd_t;

  typedef struct packed {
    cmd_t                     cmd;
    logic [IndexW-1:0]        row_index;
    logic [IndexW-1:0]        col_index;
    logic signed [DataW-1:0]  value_in;
  } req_t;

  typedef struct packed {
    logic signed [DataW-1:0]  result_value;
    logic                     range_error;
  } rsp_t;

  typedef struct packed {
    logic prod_en;
    logic addr_en;
  } addr_en_t;

  typedef struct packed {
    logic write;
    logic read;
  } store_ctl_t;

  // plan piecewise-linear sigmoid, q4.12 in, q0.15 out saturated to 32767
  function automatic logic [DataW-1:0] plan_sigmoid(input logic signed [DataW-1:0] x);
    logic [DataW-1:0] a;
    logic [DataW-1:0] y;
    a = x[DataW-1] ? (DataW'(0) - DataW'(x)) : DataW'(x);
    if (a >= 16'd20480) begin
      y = 16'd32768;
    end else if (a >= 16'd9728) begin
      y = (a >> 2) + 16'd27648;
    end else if (a >= 16'd4096) begin
      y = a + 16'd20480;
    end else begin
      y = (a << 1) + 16'd16384;
    end
    if (x[DataW-1]) begin
      y = 16'd32768 - y;
    end
    if (y > 16'd32767) begin
      y = 16'd32767;
    end
    return y;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/sigmoid_activation_gradient_unit.sv
// top level of the sigmoid activation and gradient unit
// depends on sgag_pkg, sgag_addr_gen, sgag_store, sgag_grad_unit and the defines header
`timescale 1ns / 1ps
`default_nettype none
`include "sigmoid_activation_gradient_unit_defines.svh"

// request channel req_data/req_valid/req_stall carries one element request: forward
// (x in q4.12, sigmoid stored and returned in q0.15) or backward (upstream gradient in
// q4.12, returns grad*fx*(1-fx) using the stored activation). response channel
// rsp_data/rsp_valid/rsp_stall returns one result per request, in request order.
// element address is row_index*feature_count + col_index; an address at or past the
// store depth gives range_error with result 0 and leaves the store untouched.
// feature_count is written through the apb port at byte address 0.
// throughput: one request per cycle while the receiver does not stall, set by the six-stage
// pipeline around the single-port store (one access per cycle).
// a forward write and a later backward read of the same entry both use the store in the
// same stage, so they stay in order without forwarding.
// reset clears every stage valid and sets feature_count to 1; store contents are
// undefined until written. while the receiver stalls, empty stages keep filling, and
// req_stall rises only once every stage holds a request.
module sigmoid_activation_gradient_unit #(
  parameter int STORE_DEPTH = sgag_pkg::StoreDepthDefault
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  // request channel
  input  wire sgag_pkg::req_t                 req_data,
  input  wire logic                           req_valid,
  output logic                                req_stall,
  // response channel
  output sgag_pkg::rsp_t                      rsp_data,
  output logic                                rsp_valid,
  input  wire logic                           rsp_stall,
  // apb configuration port
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [sgag_pkg::PAddrW-1:0]    paddr,
  input  wire logic [sgag_pkg::PDataW-1:0]    pwdata,
  output logic [sgag_pkg::PDataW-1:0]         prdata,
  output logic                                pready
);

  localparam int AddrW = $clog2(STORE_DEPTH);
  localparam int DataW = sgag_pkg::DataW;

  // configuration register
  logic [sgag_pkg::FeatureCountW-1:0] feature_count;

  // stage valids, stage 6 is the output register
  logic s1_valid, s2_valid, s3_valid, s4_valid, s5_valid;
  logic free1, free2, free3, free4, free5, free6;

  // payload carried alongside the address and gradient units
  sgag_pkg::req_t            s1_req;
  sgag_pkg::cmd_t            s2_cmd, s3_cmd, s4_cmd, s5_cmd;
  logic signed [DataW-1:0]   s2_value, s3_value, s4_value, s5_value;
  logic [DataW-1:0]          s2_sig, s3_sig, s4_sig, s5_sig;
  logic                      s4_range, s5_range;

  // unit interfaces
  sgag_pkg::addr_en_t        addr_en;
  logic [AddrW-1:0]          s3_addr;
  logic                      s3_range;
  sgag_pkg::store_ctl_t      store_ctl;
  logic [DataW-1:0]          s4_fx;
  logic signed [DataW-1:0]   grad_out;
  logic signed [DataW-1:0]   result_next;

  // apb: always ready, register index in paddr[2]
  assign pready = 1'b1;
  assign prdata = (paddr[2] == sgag_pkg::RegIdxFeatureCount)
                ? sgag_pkg::PDataW'(feature_count) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      feature_count <= sgag_pkg::FeatureCountReset;
    end else if (psel && penable && pwrite && pready &&
                 paddr[2] == sgag_pkg::RegIdxFeatureCount) begin
      feature_count <= pwdata[sgag_pkg::FeatureCountW-1:0];
    end
  end

  // a stage may load when empty or when its occupant moves on, so bubbles close up
  assign free6 = !rsp_valid || !rsp_stall;
  assign free5 = !s5_valid || free6;
  assign free4 = !s4_valid || free5;
  assign free3 = !s3_valid || free4;
  assign free2 = !s2_valid || free3;
  assign free1 = !s1_valid || free2;
  assign req_stall = !free1;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      s4_valid  <= 1'b0;
      s5_valid  <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (free1) s1_valid  <= req_valid;
      if (free2) s2_valid  <= s1_valid;
      if (free3) s3_valid  <= s2_valid;
      if (free4) s4_valid  <= s3_valid;
      if (free5) s5_valid  <= s4_valid;
      if (free6) rsp_valid <= s5_valid;
    end
  end

  // stage 1: captured request
  always_ff @(posedge clk) begin
    if (free1) begin
      s1_req <= req_data;
    end
  end

  // stage 2: sigmoid evaluated alongside the address multiply
  always_ff @(posedge clk) begin
    if (free2) begin
      s2_cmd   <= s1_req.cmd;
      s2_value <= s1_req.value_in;
      s2_sig   <= sgag_pkg::plan_sigmoid(s1_req.value_in);
    end
  end

  // stage 3: address and range flag ready for the store
  always_ff @(posedge clk) begin
    if (free3) begin
      s3_cmd   <= s2_cmd;
      s3_value <= s2_value;
      s3_sig   <= s2_sig;
    end
  end

  assign addr_en.prod_en = free2;
  assign addr_en.addr_en = free3;

  sgag_addr_gen #(
    .STORE_DEPTH (STORE_DEPTH)
  ) u_addr_gen (
    .clk           (clk),
    .en            (addr_en),
    .row_index     (s1_req.row_index),
    .col_index     (s1_req.col_index),
    .feature_count (feature_count),
    .addr          (s3_addr),
    .range_error   (s3_range)
  );

  // store access on the edge that moves stage 3 into stage 4
  assign store_ctl.write = free4 && s3_valid && !s3_range && (s3_cmd == sgag_pkg::CmdForward);
  assign store_ctl.read  = free4 && s3_valid && !s3_range && (s3_cmd == sgag_pkg::CmdBackward);

  sgag_store #(
    .STORE_DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .ctl   (store_ctl),
    .addr  (s3_addr),
    .wdata (s3_sig),
    .rdata (s4_fx)
  );

  // stage 4: read data from the store
  always_ff @(posedge clk) begin
    if (free4) begin
      s4_cmd   <= s3_cmd;
      s4_value <= s3_value;
      s4_sig   <= s3_sig;
      s4_range <= s3_range;
    end
  end

  // stage 5: derivative term registered inside the gradient unit
  always_ff @(posedge clk) begin
    if (free5) begin
      s5_cmd   <= s4_cmd;
      s5_value <= s4_value;
      s5_sig   <= s4_sig;
      s5_range <= s4_range;
    end
  end

  sgag_grad_unit u_grad_unit (
    .clk      (clk),
    .en       (free5),
    .fx       (s4_fx),
    .grad     (s5_value),
    .grad_out (grad_out)
  );

  // result select: zero on range error, sigmoid on forward, gradient on backward
  always_comb begin
    priority if (s5_range) begin
      result_next = '0;
    end else if (s5_cmd == sgag_pkg::CmdForward) begin
      result_next = $signed(s5_sig);
    end else begin
      result_next = grad_out;
    end
  end

  // stage 6: output register
  always_ff @(posedge clk) begin
    if (free6) begin
      rsp_data.result_value <= result_next;
      rsp_data.range_error  <= s5_range;
    end
  end

  // checks
  `SGAG_ASSERT_SAME(a_range_gives_zero, rsp_valid && rsp_data.range_error, rsp_data.result_value == '0)
  `SGAG_ASSERT_SAME(a_store_access_in_range, store_ctl.write || store_ctl.read, s3_valid && !s3_range)
  `SGAG_ASSERT_NEXT(a_forward_nonneg, s5_valid && free6 && !s5_range && s5_cmd == sgag_pkg::CmdForward, !rsp_data.result_value[DataW-1])
  `SGAG_ASSERT_SAME(a_no_stall_when_empty, !s1_valid, !req_stall)

endmodule

`default_nettype wire

FILE: rtl/sgag_addr_gen.sv
// element address generation: row times feature count, then column add and range check
// depends on sgag_pkg
`timescale 1ns / 1ps
`default_nettype none

module sgag_addr_gen #(
  parameter int STORE_DEPTH = sgag_pkg::StoreDepthDefault,
  localparam int AddrW = $clog2(STORE_DEPTH)
) (
  input  wire logic                                clk,
  input  wire sgag_pkg::addr_en_t                  en,
  input  wire logic [sgag_pkg::IndexW-1:0]         row_index,
  input  wire logic [sgag_pkg::IndexW-1:0]         col_index,
  input  wire logic [sgag_pkg::FeatureCountW-1:0]  feature_count,
  output logic [AddrW-1:0]                         addr,
  output logic                                     range_error
);

  logic [sgag_pkg::ProdW-1:0]     prod;
  logic [sgag_pkg::IndexW-1:0]    col_hold;
  logic [sgag_pkg::FullAddrW-1:0] full_addr;

  // first stage: the multiply only
  always_ff @(posedge clk) begin
    if (en.prod_en) begin
      prod     <= sgag_pkg::ProdW'(row_index) * sgag_pkg::ProdW'(feature_count);
      col_hold <= col_index;
    end
  end

  assign full_addr = sgag_pkg::FullAddrW'(prod) + sgag_pkg::FullAddrW'(col_hold);

  // second stage: column add and compare against the store depth
  always_ff @(posedge clk) begin
    if (en.addr_en) begin
      addr        <= full_addr[AddrW-1:0];
      range_error <= (full_addr >= sgag_pkg::FullAddrW'(STORE_DEPTH));
    end
  end

endmodule

`default_nettype wire

FILE: rtl/sgag_store.sv
// activation store: single-port synchronous memory with registered read data
// depends on sgag_pkg
`timescale 1ns / 1ps
`default_nettype none

module sgag_store #(
  parameter int STORE_DEPTH = sgag_pkg::StoreDepthDefault,
  localparam int AddrW = $clog2(STORE_DEPTH)
) (
  input  wire logic                          clk,
  input  wire sgag_pkg::store_ctl_t          ctl,
  input  wire logic [AddrW-1:0]              addr,
  input  wire logic [sgag_pkg::DataW-1:0]    wdata,
  output logic [sgag_pkg::DataW-1:0]         rdata
);

  logic [sgag_pkg::DataW-1:0] mem [STORE_DEPTH];

  always_ff @(posedge clk) begin
    if (ctl.write) begin
      mem[addr] <= wdata;
    end
    if (ctl.read) begin
      rdata <= mem[addr];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/sgag_grad_unit.sv
// gradient datapath: registered fx*(1-fx), then upstream gradient times that term
// depends on sgag_pkg
`timescale 1ns / 1ps
`default_nettype none

module sgag_grad_unit (
  input  wire logic                               clk,
  input  wire logic                               en,
  input  wire logic [sgag_pkg::DataW-1:0]         fx,
  input  wire logic signed [sgag_pkg::DataW-1:0]  grad,
  output logic signed [sgag_pkg::DataW-1:0]       grad_out
);

  localparam int FxW   = sgag_pkg::DataW - 1;
  localparam int DerW  = 2 * FxW;
  localparam int GpW   = 2 * sgag_pkg::DataW;

  logic [sgag_pkg::DataW-1:0] one_minus;
  logic [DerW-1:0]            der_prod;
  logic [FxW-1:0]             der;
  logic signed [GpW-1:0]      gp;

  // stored activations are q0.15 in 0..32767, sign bit never set
  assign one_minus = sgag_pkg::DataW'(17'd32768 - 17'(fx[FxW-1:0]));
  assign der_prod  = DerW'(fx[FxW-1:0]) * DerW'(one_minus);

  always_ff @(posedge clk) begin
    if (en) begin
      der <= der_prod[DerW-1:FxW];
    end
  end

  // arithmetic shift by 15 floors, result fits 16 bits
  assign gp       = GpW'(grad) * GpW'($signed({1'b0, der}));
  assign grad_out = gp[FxW+sgag_pkg::DataW-1:FxW];

endmodule

`default_nettype wire

FILE: verif/sigmoid_activation_gradient_unit_tb.sv
// self-checking testbench for the sigmoid activation and gradient unit
// drives element requests and apb register writes, predicts every response and compares it
// depends on sgag_pkg and the sigmoid_activation_gradient_unit top level only
`timescale 1ns / 1ps

module sigmoid_activation_gradient_unit_tb;

  localparam int StoreDepth = sgag_pkg::StoreDepthDefault;
  localparam int CycleLimit = 200000;
  localparam int ReportLimit = 10;
  localparam logic [sgag_pkg::PAddrW-1:0] FeatureCountAddr =
    {sgag_pkg::RegIdxFeatureCount, 2'b00};
  // an address in the apb window that holds no register
  localparam logic [sgag_pkg::PAddrW-1:0] SpareAddr = {~sgag_pkg::RegIdxFeatureCount, 2'b00};

  logic clk = 1'b0;
  logic rst = 1'b1;

  // request side, all inputs known from time zero
  sgag_pkg::req_t req_data = '0;
  logic req_valid = 1'b0;
  logic req_stall;

  // response side
  sgag_pkg::rsp_t rsp_data;
  logic rsp_valid;
  logic rsp_stall = 1'b0;

  // apb side
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [sgag_pkg::PAddrW-1:0] paddr = '0;
  logic [sgag_pkg::PDataW-1:0] pwdata = '0;
  logic [sgag_pkg::PDataW-1:0] prdata;
  logic pready;

  // local copy of the unit state: register, activation store and which entries hold data
  logic [sgag_pkg::FeatureCountW-1:0] unit_feature_count = sgag_pkg::FeatureCountReset;
  logic [sgag_pkg::DataW-1:0] activation_mirror [StoreDepth];
  bit activation_written [StoreDepth];
  int unsigned written_addrs [$];

  // responses owed by the unit, oldest first
  sgag_pkg::rsp_t responses_due [$];

  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;
  // when set, neither side inserts idle cycles
  bit quiet_stretch = 1'b0;

  sigmoid_activation_gradient_unit dut (
    .clk       (clk),
    .rst       (rst),
    .req_data  (req_data),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_data  (rsp_data),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // run guard: a hung handshake ends the run as a failure
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("timeout after %0d cycles, %0d responses outstanding", cycle_count,
               responses_due.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // roughly a third of cycles idle, except inside a quiet stretch
  function automatic bit take_break();
    return !quiet_stretch && ($urandom_range(99) < 32);
  endfunction

  // plan piecewise-linear sigmoid: q4.12 in, q0.15 out, 1.0 saturated to 32767
  function automatic logic [sgag_pkg::DataW-1:0] plan_sigmoid_q15(
    input logic signed [sgag_pkg::DataW-1:0] x);
    int xi;
    int mag;
    int y;
    xi = x;
    mag = (xi < 0) ? -xi : xi;
    if (mag >= 20480) begin
      y = 32768;
    end else if (mag >= 9728) begin
      y = (mag >> 2) + 27648;
    end else if (mag >= 4096) begin
      y = mag + 20480;
    end else begin
      y = 2 * mag + 16384;
    end
    // mirror about one half for negative x
    if (xi < 0) begin
      y = 32768 - y;
    end
    if (y > 32767) begin
      y = 32767;
    end
    return y[sgag_pkg::DataW-1:0];
  endfunction

  // works out the response to one accepted request and updates the local store
  function automatic sgag_pkg::rsp_t sigmoid_unit_response(input sgag_pkg::req_t r);
    sgag_pkg::rsp_t rsp;
    longint addr;
    logic [sgag_pkg::DataW-1:0] act;
    longint fx;
    longint slope;
    longint prod;
    rsp = '0;
    addr = longint'(r.row_index) * longint'(unit_feature_count) + longint'(r.col_index);
    // out of range: flag only, store untouched
    if (addr >= StoreDepth) begin
      rsp.range_error = 1'b1;
      return rsp;
    end
    if (r.cmd == sgag_pkg::CmdForward) begin
      act = plan_sigmoid_q15(r.value_in);
      activation_mirror[addr] = act;
      if (!activation_written[addr]) begin
        activation_written[addr] = 1'b1;
        written_addrs.push_back(int'(addr));
      end
      rsp.result_value = act;
    end else begin
      // fx*(1-fx) in q0.15, then the upstream gradient, both floored
      fx = longint'(activation_mirror[addr]);
      slope = (fx * (32768 - fx)) >>> 15;
      prod = longint'(r.value_in) * slope;
      rsp.result_value = sgag_pkg::DataW'(prod >>> 15);
    end
    return rsp;
  endfunction

  function automatic void note_mismatch();
    mismatches++;
  endfunction

  // response checker and receiver stall: values read here are the ones before the edge
  always @(posedge clk) begin
    sgag_pkg::rsp_t due;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (responses_due.size() == 0) begin
        note_mismatch();
        if (mismatches <= ReportLimit) begin
          $display("response with nothing outstanding: value %0d range_error %0b",
                   rsp_data.result_value, rsp_data.range_error);
        end
      end else begin
        due = responses_due.pop_front();
        if ((rsp_data.result_value !== due.result_value) ||
            (rsp_data.range_error !== due.range_error)) begin
          note_mismatch();
          if (mismatches <= ReportLimit) begin
            $display("response mismatch: expected value %0d range_error %0b, got %0d %0b",
                     due.result_value, due.range_error,
                     rsp_data.result_value, rsp_data.range_error);
          end
        end
      end
    end
    rsp_stall <= take_break();
  end

  // one request through the valid/stall handshake, with random idle cycles ahead of it
  task automatic send_request(input sgag_pkg::req_t r);
    while (take_break()) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_data <= r;
    req_valid <= 1'b1;
    do @(posedge clk); while (req_stall);
    responses_due.push_back(sigmoid_unit_response(r));
  endtask

  function automatic sgag_pkg::req_t make_request(input sgag_pkg::cmd_t cmd,
                                                  input int unsigned row,
                                                  input int unsigned col, input int value);
    sgag_pkg::req_t r;
    r.cmd = cmd;
    r.row_index = sgag_pkg::IndexW'(row);
    r.col_index = sgag_pkg::IndexW'(col);
    r.value_in = sgag_pkg::DataW'(value);
    return r;
  endfunction

  // stop sending and wait until the unit owes nothing
  task automatic drain_responses();
    req_valid <= 1'b0;
    do @(posedge clk); while (responses_due.size() != 0);
  endtask

  // apb write: setup cycle, access cycle, then psel dropped before returning
  task automatic apb_write(input logic [sgag_pkg::PAddrW-1:0] addr,
                           input logic [sgag_pkg::PDataW-1:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (addr == FeatureCountAddr) begin
      unit_feature_count = data[sgag_pkg::FeatureCountW-1:0];
    end
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  // apb read of feature_count, compared with the local copy
  task automatic check_feature_count_readback();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= FeatureCountAddr;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata[sgag_pkg::FeatureCountW-1:0] !== unit_feature_count) begin
      note_mismatch();
      if (mismatches <= ReportLimit) begin
        $display("feature_count readback: expected %0d, got %0d", unit_feature_count,
                 prdata[sgag_pkg::FeatureCountW-1:0]);
      end
    end
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // register write only while idle, then read back
  task automatic set_feature_count(input int unsigned count);
    drain_responses();
    apb_write(FeatureCountAddr, sgag_pkg::PDataW'(count));
    check_feature_count_readback();
  endtask

  // split a flat element address into row and column for the current feature_count
  function automatic void place_address(inout sgag_pkg::req_t r, input int unsigned addr);
    if (unit_feature_count == 0) begin
      // zero feature count: the row plays no part
      r.row_index = sgag_pkg::IndexW'($urandom_range(1023));
      r.col_index = sgag_pkg::IndexW'(addr);
    end else begin
      r.row_index = sgag_pkg::IndexW'(addr / unit_feature_count);
      r.col_index = sgag_pkg::IndexW'(addr % unit_feature_count);
    end
  endfunction

  // input value: half fully random, half around the segment boundaries of the curve
  function automatic logic [sgag_pkg::DataW-1:0] random_value();
    int knee;
    int v;
    if ($urandom_range(1) == 0) begin
      return sgag_pkg::DataW'($urandom);
    end
    case ($urandom_range(3))
      0: knee = 0;
      1: knee = 4096;
      2: knee = 9728;
      default: knee = 20480;
    endcase
    v = knee + $urandom_range(64) - 32;
    if ($urandom_range(1) == 1) begin
      v = -v;
    end
    return sgag_pkg::DataW'(v);
  endfunction

  // mostly forward then backward passes over live elements, some noise addresses
  task automatic send_random_requests(input int unsigned count);
    int unsigned sent;
    int unsigned roll;
    int unsigned addr;
    longint flat;
    sgag_pkg::req_t r;
    sent = 0;
    while (sent < count) begin
      roll = $urandom_range(99);
      r = '0;
      r.value_in = random_value();
      if (roll < 15) begin
        // noise: any row and column, usually past the end of the store
        r.cmd = ($urandom_range(1) == 1) ? sgag_pkg::CmdBackward : sgag_pkg::CmdForward;
        r.row_index = sgag_pkg::IndexW'($urandom_range(1023));
        r.col_index = sgag_pkg::IndexW'($urandom_range(1023));
        flat = longint'(r.row_index) * longint'(unit_feature_count) + longint'(r.col_index);
        // never read an entry that no forward request has written
        if (flat < StoreDepth && !activation_written[flat]) begin
          r.cmd = sgag_pkg::CmdForward;
        end
        send_request(r);
        sent++;
      end else if (roll < 55 || written_addrs.size() == 0) begin
        addr = $urandom_range(StoreDepth - 1);
        r.cmd = sgag_pkg::CmdForward;
        place_address(r, addr);
        send_request(r);
        sent++;
        // often chase a forward pass with the backward pass of the same element
        if ($urandom_range(99) < 40) begin
          r.cmd = sgag_pkg::CmdBackward;
          r.value_in = sgag_pkg::DataW'($urandom);
          place_address(r, addr);
          send_request(r);
          sent++;
        end
      end else begin
        addr = written_addrs[$urandom_range(written_addrs.size() - 1)];
        r.cmd = sgag_pkg::CmdBackward;
        r.value_in = sgag_pkg::DataW'($urandom);
        place_address(r, addr);
        send_request(r);
        sent++;
      end
    end
  endtask

  // forward at every segment boundary and both extremes, then gradients of those entries
  task automatic test_sigmoid_breakpoints();
    int xs [13] = '{0, 4095, 4096, 9727, 9728, 20479, 20480, 32767, -32768, -1, -4096,
                    -9728, -20480};
    foreach (xs[k]) begin
      send_request(make_request(sgag_pkg::CmdForward, 0, k, xs[k]));
    end
    // fx one half, full-scale gradients of both signs
    send_request(make_request(sgag_pkg::CmdBackward, 0, 0, 32767));
    send_request(make_request(sgag_pkg::CmdBackward, 0, 0, -32768));
    // saturated and zero activations
    send_request(make_request(sgag_pkg::CmdBackward, 0, 7, 32767));
    send_request(make_request(sgag_pkg::CmdBackward, 0, 8, -32768));
    // small negative gradient, floored towards minus infinity
    send_request(make_request(sgag_pkg::CmdBackward, 0, 9, -1));
    send_request(make_request(sgag_pkg::CmdBackward, 0, 3, 1));
  endtask

  // last entry of the store, one past it, and the largest indices (feature_count is 1 here)
  task automatic test_address_range();
    send_request(make_request(sgag_pkg::CmdForward, 0, 1023, 12345));
    send_request(make_request(sgag_pkg::CmdForward, 1, 1023, -777));
    send_request(make_request(sgag_pkg::CmdBackward, 1023, 1023, 4000));
    send_request(make_request(sgag_pkg::CmdBackward, 1, 1022, -1234));
  endtask

  // upper write bits are dropped, the spare address leaves feature_count alone
  task automatic test_register_access();
    drain_responses();
    apb_write(FeatureCountAddr, 32'hFFFF_F806);
    check_feature_count_readback();
    apb_write(SpareAddr, $urandom);
    check_feature_count_readback();
    send_random_requests(20);
  endtask

  // random traffic over several feature counts, the width extremes among them
  task automatic test_random_traffic();
    int unsigned counts [8];
    counts = '{1024, 0, 2047, 1, 5, $urandom_range(1023, 2), $urandom_range(1024, 1), 33};
    foreach (counts[p]) begin
      set_feature_count(counts[p]);
      // one phase with both sides running flat out
      quiet_stretch = (p == 4);
      send_random_requests(55);
      // sender holds off until the unit has answered everything
      if (p == 2) begin
        drain_responses();
      end
      send_random_requests(55);
      quiet_stretch = 1'b0;
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_sigmoid_breakpoints();
    test_address_range();
    test_register_access();
    test_random_traffic();
    drain_responses();
    // allow for any stray response past the pipeline depth
    repeat (12) @(posedge clk);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+rtl
rtl/sgag_pkg.sv
rtl/sgag_addr_gen.sv
rtl/sgag_store.sv
rtl/sgag_grad_unit.sv
rtl/sigmoid_activation_gradient_unit.sv
verif/sigmoid_activation_gradient_unit_tb.sv
